// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and keyword tables for the C subset token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int KIND_W    = 5;
    localparam int LEN_OUT_W = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    typedef enum logic [KIND_W-1:0] {
        K_IDENT      = 5'd0,
        K_INT        = 5'd1,
        K_KW_BOOL    = 5'd2,
        K_KW_INT     = 5'd3,
        K_KW_RETURN  = 5'd4,
        K_KW_IF      = 5'd5,
        K_KW_ELSE    = 5'd6,
        K_LPAREN     = 5'd7,
        K_RPAREN     = 5'd8,
        K_LBRACE     = 5'd9,
        K_RBRACE     = 5'd10,
        K_SEMI       = 5'd11,
        K_COMMA      = 5'd12,
        K_EQ_EQ      = 5'd13,
        K_NE         = 5'd14,
        K_LE         = 5'd15,
        K_GE         = 5'd16,
        K_LT         = 5'd17,
        K_GT         = 5'd18,
        K_PLUS       = 5'd19,
        K_MINUS      = 5'd20,
        K_STAR       = 5'd21,
        K_SLASH      = 5'd22,
        K_PERCENT    = 5'd23,
        K_UNEXPECTED = 5'd24,
        K_END        = 5'd25
    } t_kind;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_IDENT = 7'b0000010,
        MODE_INT   = 7'b0000100,
        MODE_LT    = 7'b0001000,
        MODE_GT    = 7'b0010000,
        MODE_EQ    = 7'b0100000,
        MODE_BANG  = 7'b1000000
    } t_mode;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_US      = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // keyword order: bool, int, return, if, else
    localparam int NUM_KW = 5;
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd3, 3'd6, 3'd2, 3'd4};

    // keywords whose character at position p equals c
    function automatic logic [NUM_KW-1:0] kw_hit(input logic [2:0] p, input logic [7:0] c);
        logic [NUM_KW-1:0] h;
        h = '0;
        case (p)
            3'd0: begin
                h[0] = (c == "b");
                h[1] = (c == "i");
                h[2] = (c == "r");
                h[3] = (c == "i");
                h[4] = (c == "e");
            end
            3'd1: begin
                h[0] = (c == "o");
                h[1] = (c == "n");
                h[2] = (c == "e");
                h[3] = (c == "f");
                h[4] = (c == "l");
            end
            3'd2: begin
                h[0] = (c == "o");
                h[1] = (c == "t");
                h[2] = (c == "t");
                h[4] = (c == "s");
            end
            3'd3: begin
                h[0] = (c == "l");
                h[2] = (c == "u");
                h[4] = (c == "e");
            end
            3'd4: h[2] = (c == "r");
            3'd5: h[2] = (c == "n");
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

// ===== hw/rtl/c_subset_token_scanner_top.sv =====
// Path: the first token closed by a byte passes through a queue entry and then the output
// register; a second token closed by the same byte follows once the first is taken.
// Throughput: one byte per cycle in unless stalled; input stall rises only when the queue
// is full. One token per cycle out while the sink does not stall. A byte that closes two
// tokens yields them in turn, and the 4-entry queue absorbs the difference.
// Reset (synchronous, active low): position and scan state to zero, queue and output empty.
// ----------------------------------------------------------------------------
// c_subset_token_scanner_top
// Streaming tokenizer for a small C subset: byte stream in, token stream out.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_top import cts_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int LINE_BITS     = 24,
    parameter int COLUMN_BITS   = 16,
    parameter int OFFSET_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_ch,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [KIND_W-1:0]      o_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [LEN_OUT_W-1:0]   o_length,
    output logic [LINE_BITS-1:0]   o_start_line,
    output logic [COLUMN_BITS-1:0] o_start_column,
    output logic                   o_last
);

    localparam int TOK_W   = KIND_W + OFFSET_BITS + LEN_OUT_W + LINE_BITS + COLUMN_BITS;
    localparam int ENTRY_W = 1 + 2 * TOK_W;
    localparam int COL_LO  = 0;
    localparam int LINE_LO = COL_LO + COLUMN_BITS;
    localparam int LEN_LO  = LINE_LO + LINE_BITS;
    localparam int OFF_LO  = LEN_LO + LEN_OUT_W;
    localparam int KIND_LO = OFF_LO + OFFSET_BITS;

    logic               accept;
    logic               push, two;
    logic [TOK_W-1:0]   tok0, tok1, out_tok;
    logic               q_full, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_head;

    assign accept  = i_valid && !q_full;
    assign o_stall = q_full;

    cts_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS),
        .OFFSET_BITS   (OFFSET_BITS),
        .TOK_W         (TOK_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_ch),
        .o_push   (push),
        .o_two    (two),
        .o_tok0   (tok0),
        .o_tok1   (tok1)
    );

    cts_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({two, tok1, tok0}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    cts_back #(
        .TOK_W (TOK_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_two   (q_head[ENTRY_W-1]),
        .i_q_tok0  (q_head[TOK_W-1:0]),
        .i_q_tok1  (q_head[2*TOK_W-1:TOK_W]),
        .i_stall   (i_stall),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_tok     (out_tok),
        .o_last    (o_last)
    );

    assign o_kind         = out_tok[KIND_LO +: KIND_W];
    assign o_start_offset = out_tok[OFF_LO  +: OFFSET_BITS];
    assign o_length       = out_tok[LEN_LO  +: LEN_OUT_W];
    assign o_start_line   = out_tok[LINE_LO +: LINE_BITS];
    assign o_start_column = out_tok[COL_LO  +: COLUMN_BITS];

endmodule

// ===== hw/rtl/cts_front.sv =====
// ----------------------------------------------------------------------------
// cts_front
// Scanner front: tracks position and pending token, classifies each byte
// and pushes the zero, one or two tokens it closes into the queue.
// ----------------------------------------------------------------------------
module cts_front import cts_pkg::*; #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int LINE_BITS     = 24,
    parameter int COLUMN_BITS   = 16,
    parameter int OFFSET_BITS   = 32,
    parameter int TOK_W         = KIND_W + OFFSET_BITS + LEN_OUT_W + LINE_BITS + COLUMN_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_ch,
    output logic             o_push,
    output logic             o_two,
    output logic [TOK_W-1:0] o_tok0,
    output logic [TOK_W-1:0] o_tok1
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    t_mode                  r_mode,     n_mode;
    logic [NUM_KW-1:0]      r_cand,     n_cand;
    logic [LEN_W-1:0]       r_tok_len,  n_tok_len;
    logic [OFFSET_BITS-1:0] r_tok_off,  n_tok_off;
    logic [LINE_BITS-1:0]   r_tok_line, n_tok_line;
    logic [COLUMN_BITS-1:0] r_tok_col,  n_tok_col;
    logic [OFFSET_BITS-1:0] r_cur_off,  n_cur_off;
    logic [LINE_BITS-1:0]   r_cur_line, n_cur_line;
    logic [COLUMN_BITS-1:0] r_cur_col,  n_cur_col;

    logic                 alpha, digit, cont, pair;
    logic                 emit_a, emit_b;
    t_kind                kind_a, kind_b, ident_k;
    logic [LEN_OUT_W-1:0] len_a, len_b;
    logic [NUM_KW-1:0]    len_hit;
    logic [TOK_W-1:0]     tok_a, tok_b;
    logic [OFFSET_BITS-1:0] adv_off;
    logic [COLUMN_BITS-1:0] adv_col;
    logic [LEN_W-1:0]       inc_len;

    assign alpha = is_alpha(i_ch);
    assign digit = is_digit(i_ch);

    assign adv_off = r_cur_off + OFFSET_BITS'(1);
    assign adv_col = (r_cur_col == '1) ? r_cur_col : r_cur_col + COLUMN_BITS'(1);
    assign inc_len = (r_tok_len == LEN_W'(MAX_TOKEN_LEN)) ? r_tok_len
                                                          : r_tok_len + LEN_W'(1);

    always_comb begin
        ident_k = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            len_hit[i] = (r_tok_len == LEN_W'(KW_LEN[i]));
            if (r_cand[i] && len_hit[i]) begin
                ident_k = t_kind'(KIND_W'(K_KW_BOOL) + KIND_W'(i));
            end
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_cand     = r_cand;
        n_tok_len  = r_tok_len;
        n_tok_off  = r_tok_off;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_cur_off  = r_cur_off;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        cont       = 1'b0;
        pair       = 1'b0;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        kind_a     = K_UNEXPECTED;
        kind_b     = K_UNEXPECTED;
        len_a      = LEN_OUT_W'(r_tok_len);
        len_b      = LEN_OUT_W'(1);

        unique case (r_mode)
            MODE_IDENT: begin
                if (alpha || digit || (i_ch == CH_US)) begin
                    cont = 1'b1;
                end else begin
                    emit_a = 1'b1;
                    kind_a = ident_k;
                end
            end
            MODE_INT: begin
                if (digit) begin
                    cont = 1'b1;
                end else begin
                    emit_a = 1'b1;
                    kind_a = K_INT;
                end
            end
            MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
                emit_a = 1'b1;
                if (i_ch == CH_EQ) begin
                    pair  = 1'b1;
                    len_a = LEN_OUT_W'(2);
                    unique case (r_mode)
                        MODE_LT: kind_a = K_LE;
                        MODE_GT: kind_a = K_GE;
                        MODE_EQ: kind_a = K_EQ_EQ;
                        default: kind_a = K_NE;
                    endcase
                end else begin
                    unique case (r_mode)
                        MODE_LT: kind_a = K_LT;
                        MODE_GT: kind_a = K_GT;
                        default: kind_a = K_UNEXPECTED;
                    endcase
                end
            end
            default: ;
        endcase

        if (cont) begin
            if (r_mode == MODE_IDENT) begin
                n_cand = (r_tok_len <= LEN_W'(7)) ? (r_cand & kw_hit(r_tok_len[2:0], i_ch))
                                                 : '0;
            end
            n_tok_len = inc_len;
            n_cur_off = adv_off;
            n_cur_col = adv_col;
        end else if (pair) begin
            n_mode    = MODE_IDLE;
            n_cur_off = adv_off;
            n_cur_col = adv_col;
        end else begin
            n_mode = MODE_IDLE;
            if (i_ch == CH_NUL) begin
                emit_b     = 1'b1;
                kind_b     = K_END;
                len_b      = '0;
                n_cand     = '0;
                n_cur_off  = '0;
                n_cur_line = '0;
                n_cur_col  = '0;
            end else if (i_ch == CH_SPACE) begin
                n_cur_off = adv_off;
                n_cur_col = adv_col;
            end else if (i_ch == CH_NL) begin
                n_cur_off  = adv_off;
                n_cur_col  = '0;
                n_cur_line = (r_cur_line == '1) ? r_cur_line : r_cur_line + LINE_BITS'(1);
            end else begin
                n_cur_off = adv_off;
                n_cur_col = adv_col;
                if (alpha || digit || (i_ch == CH_LT) || (i_ch == CH_GT) ||
                        (i_ch == CH_EQ) || (i_ch == CH_BANG)) begin
                    n_tok_len  = LEN_W'(1);
                    n_tok_off  = r_cur_off;
                    n_tok_line = r_cur_line;
                    n_tok_col  = r_cur_col;
                    if (alpha) begin
                        n_mode = MODE_IDENT;
                        n_cand = kw_hit(3'd0, i_ch);
                    end else if (digit) begin
                        n_mode = MODE_INT;
                    end else if (i_ch == CH_LT) begin
                        n_mode = MODE_LT;
                    end else if (i_ch == CH_GT) begin
                        n_mode = MODE_GT;
                    end else if (i_ch == CH_EQ) begin
                        n_mode = MODE_EQ;
                    end else begin
                        n_mode = MODE_BANG;
                    end
                end else begin
                    emit_b = 1'b1;
                    case (i_ch)
                        CH_LPAREN:  kind_b = K_LPAREN;
                        CH_RPAREN:  kind_b = K_RPAREN;
                        CH_LBRACE:  kind_b = K_LBRACE;
                        CH_RBRACE:  kind_b = K_RBRACE;
                        CH_SEMI:    kind_b = K_SEMI;
                        CH_COMMA:   kind_b = K_COMMA;
                        CH_PLUS:    kind_b = K_PLUS;
                        CH_MINUS:   kind_b = K_MINUS;
                        CH_STAR:    kind_b = K_STAR;
                        CH_SLASH:   kind_b = K_SLASH;
                        CH_PERCENT: kind_b = K_PERCENT;
                        default:    kind_b = K_UNEXPECTED;
                    endcase
                end
            end
        end
    end

    assign tok_a = {kind_a, r_tok_off, len_a, r_tok_line, r_tok_col};
    assign tok_b = {kind_b, r_cur_off, len_b, r_cur_line, r_cur_col};

    assign o_push = i_accept && (emit_a || emit_b);
    assign o_two  = emit_a && emit_b;
    assign o_tok0 = emit_a ? tok_a : tok_b;
    assign o_tok1 = tok_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_cand     <= '0;
            r_tok_len  <= '0;
            r_tok_off  <= '0;
            r_tok_line <= '0;
            r_tok_col  <= '0;
            r_cur_off  <= '0;
            r_cur_line <= '0;
            r_cur_col  <= '0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_cand     <= n_cand;
            r_tok_len  <= n_tok_len;
            r_tok_off  <= n_tok_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_cur_off  <= n_cur_off;
            r_cur_line <= n_cur_line;
            r_cur_col  <= n_cur_col;
        end
    end

`ifndef SYNTHESIS
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("scan mode not one-hot");
    a_pair_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair |-> !emit_b)
        else $error("two-char operator also emitted a second token");
    a_tok_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= LEN_W'(MAX_TOKEN_LEN))
        else $error("token length above limit");
`endif

endmodule

// ===== hw/rtl/cts_queue.sv =====
// ----------------------------------------------------------------------------
// cts_queue
// Short register queue between scanner front and output stage. Each entry
// holds the tokens closed by one byte: one or two.
// ----------------------------------------------------------------------------
module cts_queue import cts_pkg::*; #(
    parameter int ENTRY_W = 171
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [ENTRY_W-1:0] i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output logic [ENTRY_W-1:0] o_data
);

    logic [ENTRY_W-1:0] r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        Q_PTR_W'(r_count) == (r_wr_ptr - r_rd_ptr))
        else $error("queue count and pointers disagree");
`endif

endmodule

// ===== hw/rtl/cts_back.sv =====
// ----------------------------------------------------------------------------
// cts_back
// Output stage: takes queue entries apart into single tokens and holds each
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module cts_back import cts_pkg::*; #(
    parameter int TOK_W = 85
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic             i_q_two,
    input  logic [TOK_W-1:0] i_q_tok0,
    input  logic [TOK_W-1:0] i_q_tok1,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output logic [TOK_W-1:0] o_tok,
    output logic             o_last
);

    logic             r_valid, n_valid;
    logic             r_sel,   n_sel;
    logic [TOK_W-1:0] r_tok;
    logic             r_last;
    logic             load, tail;

    assign load  = i_q_valid && (!r_valid || !i_stall);
    assign tail  = r_sel || !i_q_two;
    assign o_pop = load && tail;

    always_comb begin
        n_sel   = r_sel;
        n_valid = r_valid && i_stall;
        if (load) begin
            n_sel   = !tail;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= r_sel ? i_q_tok1 : i_q_tok0;
            r_last <= tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_last  = r_last;

`ifndef SYNTHESIS
    a_sel_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_q_valid && i_q_two))
        else $error("second token selected without a two-token entry");
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (r_valid && !r_last))
        else $error("second token pending after a last token");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !load)
        else $error("output register reloaded while stalled");
`endif

endmodule

// ===== test/tb_c_subset_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// tb_c_subset_token_scanner_top
// Self-checking bench for the token scanner. A short table of source bytes
// covers every token kind but the keywords bool, int, return and else, and the
// error paths. Generated C-like text follows, including one identifier past the
// length limit. Input gaps and output stalls come in random bursts. Every token
// is compared field by field against a bench scanner model or a typed table row.
// ----------------------------------------------------------------------------
module tb_c_subset_token_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int          MAX_TOKEN_LEN  = 255;
    localparam int          RANDOM_ITEMS   = 500;
    localparam int          LONG_IDENT     = 260;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          QUIET_TAIL     = 80;
    localparam logic [7:0]  CH_TAB         = 8'h09;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] off;
        logic [7:0]  len;
        logic [23:0] line;
        logic [15:0] col;
        logic        last;
    } t_tok;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        t_kind       kind;
        logic [31:0] off;
    } t_dir_row;

    typedef struct {
        logic [7:0] ch;
        logic       typed;
        t_tok       tok;
    } t_feed_row;

    localparam int N_DIR = 36;
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{CH_NUL,     1'b1, K_END,        32'd0},
        '{CH_LPAREN,  1'b1, K_LPAREN,     32'd0},
        '{CH_RPAREN,  1'b1, K_RPAREN,     32'd1},
        '{CH_LBRACE,  1'b1, K_LBRACE,     32'd2},
        '{CH_RBRACE,  1'b1, K_RBRACE,     32'd3},
        '{CH_SEMI,    1'b1, K_SEMI,       32'd4},
        '{CH_COMMA,   1'b1, K_COMMA,      32'd5},
        '{CH_PLUS,    1'b1, K_PLUS,       32'd6},
        '{CH_MINUS,   1'b1, K_MINUS,      32'd7},
        '{CH_STAR,    1'b1, K_STAR,       32'd8},
        '{CH_SLASH,   1'b1, K_SLASH,      32'd9},
        '{CH_PERCENT, 1'b1, K_PERCENT,    32'd10},
        '{CH_LT,      1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_GT,      1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_BANG,    1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_LT,      1'b0, K_IDENT,      32'd0},
        '{CH_GT,      1'b0, K_IDENT,      32'd0},
        '{CH_BANG,    1'b0, K_IDENT,      32'd0},
        '{CH_US,      1'b1, K_UNEXPECTED, 32'd22},
        '{CH_TAB,     1'b1, K_UNEXPECTED, 32'd23},
        '{8'hFF,      1'b1, K_UNEXPECTED, 32'd24},
        '{"1",        1'b0, K_IDENT,      32'd0},
        '{"2",        1'b0, K_IDENT,      32'd0},
        '{"a",        1'b0, K_IDENT,      32'd0},
        '{"b",        1'b0, K_IDENT,      32'd0},
        '{CH_NL,      1'b0, K_IDENT,      32'd0},
        '{"i",        1'b0, K_IDENT,      32'd0},
        '{"f",        1'b0, K_IDENT,      32'd0},
        '{CH_SPACE,   1'b0, K_IDENT,      32'd0},
        '{CH_EQ,      1'b0, K_IDENT,      32'd0},
        '{CH_NUL,     1'b0, K_IDENT,      32'd0}
    };

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [7:0]           i_ch    = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [31:0]          o_start_offset;
    logic [LEN_OUT_W-1:0] o_length;
    logic [23:0]          o_start_line;
    logic [15:0]          o_start_column;
    logic                 o_last;

    c_subset_token_scanner_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_start_offset (o_start_offset),
        .o_length       (o_length),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_last         (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // scanner model state
    t_mode             sc_mode;
    logic [NUM_KW-1:0] kw_live;
    logic [7:0]        tok_len;
    logic [31:0]       tok_off;
    logic [23:0]       tok_line;
    logic [15:0]       tok_col;
    logic [31:0]       pos_off;
    logic [23:0]       pos_line;
    logic [15:0]       pos_col;

    t_tok      step_toks[$];
    t_tok      tokens_due[$];
    t_feed_row feed[$];

    int errors      = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int busy_bytes  = 0;
    bit pacing_on   = 1'b1;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic string kw_word(input int i);
        case (i)
            0: return "bool";
            1: return "int";
            2: return "return";
            3: return "if";
            default: return "else";
        endcase
    endfunction

    task automatic scanner_clear();
        sc_mode  = MODE_IDLE;
        kw_live  = '0;
        tok_len  = '0;
        tok_off  = '0;
        tok_line = '0;
        tok_col  = '0;
        pos_off  = '0;
        pos_line = '0;
        pos_col  = '0;
    endtask

    task automatic emit_tok(input t_kind k, input logic [31:0] o, input logic [7:0] l,
                            input logic [23:0] ln, input logic [15:0] cl);
        t_tok t;
        t.kind = k;
        t.off  = o;
        t.len  = l;
        t.line = ln;
        t.col  = cl;
        t.last = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic emit_held(input t_kind k);
        emit_tok(k, tok_off, tok_len, tok_line, tok_col);
    endtask

    task automatic step_col();
        pos_off = pos_off + 1;
        if (pos_col != '1) pos_col = pos_col + 1;
    endtask

    task automatic begin_tok(input t_mode m);
        sc_mode  = m;
        tok_len  = 8'd1;
        tok_off  = pos_off;
        tok_line = pos_line;
        tok_col  = pos_col;
    endtask

    task automatic narrow_kw(input logic [7:0] c);
        string w;
        int    i;
        for (i = 0; i < NUM_KW; i++) begin
            w = kw_word(i);
            if ((tok_len >= w.len()) || (w[tok_len] != c)) kw_live[i] = 1'b0;
        end
    endtask

    // tokens caused by one byte land in step_toks
    task automatic scan_byte(input logic [7:0] c);
        t_kind k;
        logic  held;
        int    i;
        string w;
        held = 1'b0;
        step_toks.delete();
        case (sc_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_num(c) || (c == CH_US)) begin
                    narrow_kw(c);
                    if (tok_len != MAX_TOKEN_LEN) tok_len = tok_len + 1;
                    step_col();
                    held = 1'b1;
                end else begin
                    k = K_IDENT;
                    for (i = NUM_KW - 1; i >= 0; i--) begin
                        w = kw_word(i);
                        if (kw_live[i] && (tok_len == w.len())) k = t_kind'(K_KW_BOOL + i);
                    end
                    emit_held(k);
                end
            end
            MODE_INT: begin
                if (is_num(c)) begin
                    if (tok_len != MAX_TOKEN_LEN) tok_len = tok_len + 1;
                    step_col();
                    held = 1'b1;
                end else begin
                    emit_held(K_INT);
                end
            end
            MODE_LT, MODE_GT, MODE_EQ, MODE_BANG: begin
                if (c == CH_EQ) begin
                    tok_len = 8'd2;
                    case (sc_mode)
                        MODE_LT: k = K_LE;
                        MODE_GT: k = K_GE;
                        MODE_EQ: k = K_EQ_EQ;
                        default: k = K_NE;
                    endcase
                    emit_held(k);
                    sc_mode = MODE_IDLE;
                    step_col();
                    held = 1'b1;
                end else begin
                    case (sc_mode)
                        MODE_LT: k = K_LT;
                        MODE_GT: k = K_GT;
                        default: k = K_UNEXPECTED;
                    endcase
                    emit_held(k);
                end
            end
            default: ;
        endcase
        if (!held) begin
            sc_mode = MODE_IDLE;
            if (c == CH_NUL) begin
                emit_tok(K_END, pos_off, 8'd0, pos_line, pos_col);
                scanner_clear();
            end else if (c == CH_SPACE) begin
                step_col();
            end else if (c == CH_NL) begin
                pos_off = pos_off + 1;
                pos_col = '0;
                if (pos_line != '1) pos_line = pos_line + 1;
            end else begin
                if (is_letter(c)) begin
                    begin_tok(MODE_IDENT);
                    kw_live = '1;
                    tok_len = '0;
                    narrow_kw(c);
                    tok_len = 8'd1;
                end else if (is_num(c)) begin
                    begin_tok(MODE_INT);
                end else if (c == CH_LT) begin
                    begin_tok(MODE_LT);
                end else if (c == CH_GT) begin
                    begin_tok(MODE_GT);
                end else if (c == CH_EQ) begin
                    begin_tok(MODE_EQ);
                end else if (c == CH_BANG) begin
                    begin_tok(MODE_BANG);
                end else begin
                    case (c)
                        CH_LPAREN:  k = K_LPAREN;
                        CH_RPAREN:  k = K_RPAREN;
                        CH_LBRACE:  k = K_LBRACE;
                        CH_RBRACE:  k = K_RBRACE;
                        CH_SEMI:    k = K_SEMI;
                        CH_COMMA:   k = K_COMMA;
                        CH_PLUS:    k = K_PLUS;
                        CH_MINUS:   k = K_MINUS;
                        CH_STAR:    k = K_STAR;
                        CH_SLASH:   k = K_SLASH;
                        CH_PERCENT: k = K_PERCENT;
                        default:    k = K_UNEXPECTED;
                    endcase
                    emit_tok(k, pos_off, 8'd1, pos_line, pos_col);
                end
                step_col();
            end
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endtask

    task automatic add_row(input logic [7:0] c);
        t_feed_row r;
        r.ch    = c;
        r.typed = 1'b0;
        r.tok   = '0;
        feed.push_back(r);
        busy_bytes++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_row(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range("a", "z"));
        return 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return rand_letter();
        if (r < 9) return 8'($urandom_range("0", "9"));
        return CH_US;
    endfunction

    task automatic add_random_token();
        int    pick;
        int    i;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            add_text(kw_word($urandom_range(0, NUM_KW - 1)));
        end else if (pick < 33) begin
            w = kw_word($urandom_range(0, NUM_KW - 1));
            case ($urandom_range(0, 3))
                0: add_text(w.substr(0, w.len() - 2));
                1: begin
                    add_text(w);
                    add_row(rand_word_char());
                end
                default: begin
                    add_row(rand_letter());
                    n = $urandom_range(0, 7);
                    for (i = 0; i < n; i++) add_row(rand_word_char());
                end
            endcase
        end else if (pick < 43) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) add_row(8'($urandom_range("0", "9")));
        end else if (pick < 58) begin
            w = "(){};,+-*/%<>";
            add_row(w[$urandom_range(0, w.len() - 1)]);
        end else if (pick < 72) begin
            w = "=!<>";
            add_row(w[$urandom_range(0, w.len() - 1)]);
            add_row(CH_EQ);
        end else if (pick < 80) begin
            // lone '=' or '!'
            add_row(($urandom_range(0, 1) != 0) ? CH_EQ : CH_BANG);
        end else if (pick < 91) begin
            add_row(8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
            add_row(CH_NUL);
        end
        pick = $urandom_range(0, 9);
        if (pick >= 8) add_row(CH_NL);
        if (pick >= 4) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) add_row(CH_SPACE);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // result checking, output stall bursts, watchdog count
    always @(posedge i_clk) begin : result_side
        t_tok want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (tokens_due.size() == 0) begin
                    $error("unrequested token: kind %0d offset %0d", o_kind, o_start_offset);
                    errors++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("start_offset", want.off, o_start_offset);
                    check_field("length", want.len, o_length);
                    check_field("start_line", want.line, o_start_line);
                    check_field("start_column", want.col, o_start_column);
                    check_field("last", want.last, o_last);
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (stall_left > 0) stall_left--;
            else if (pacing_on && ($urandom_range(0, 9) == 0))
                stall_left = $urandom_range(1, 12);
            i_stall <= (stall_left > 0);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_feed_row r;
        int        n;
        bit        long_done;

        scanner_clear();
        long_done = 1'b0;
        foreach (DIR_TAB[j]) begin
            r.ch       = DIR_TAB[j].ch;
            r.typed    = DIR_TAB[j].typed;
            r.tok.kind = DIR_TAB[j].kind;
            r.tok.off  = DIR_TAB[j].off;
            r.tok.len  = (DIR_TAB[j].kind == K_END) ? 8'd0 : 8'd1;
            r.tok.line = '0;
            r.tok.col  = DIR_TAB[j].off[15:0];
            r.tok.last = 1'b1;
            feed.push_back(r);
        end
        busy_bytes = 0;
        while (busy_bytes < RANDOM_ITEMS) begin
            if (!long_done && (busy_bytes >= RANDOM_ITEMS / 4)) begin
                // length saturation
                long_done = 1'b1;
                add_row(CH_NL);
                add_row("q");
                for (n = 0; n < LONG_IDENT; n++) add_row(rand_word_char());
                add_row(CH_SPACE);
                add_text("x1 == 7;");
                add_row(CH_NL);
            end
            add_random_token();
        end
        add_row(CH_NUL);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (n = 0; n < feed.size(); n++) begin
            pacing_on = (n < feed.size() - QUIET_TAIL);
            if (pacing_on && ($urandom_range(0, 9) == 0)) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_ch    <= feed[n].ch;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            scan_byte(feed[n].ch);
            if (feed[n].typed) begin
                if (step_toks.size() == 0) step_toks.push_back(feed[n].tok);
                else step_toks[step_toks.size() - 1] = feed[n].tok;
            end
            foreach (step_toks[j]) tokens_due.push_back(step_toks[j]);
        end
        i_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
